// File: hdl/stihr_pkg.sv
// Shared types, constants and the ADC-to-temperature conversion for the
// solder tip heater regulator. No dependencies.
`timescale 1ns / 1ps

package stihr_pkg;

  localparam int ADC_W   = 12;
  localparam int TEMP_W  = 8;
  localparam int DUTY_W  = 10;   // duty field on the result beat
  localparam int CNT_W   = 16;
  localparam int GAIN_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Duty ceiling; the stored duty is as wide as the ceiling needs.
  localparam int DUTY_MAX   = 1023;
  localparam int DUTY_VAL_W = $clog2(DUTY_MAX + 1);

  // Q16 form of (0.1282 * adc + 12.42) / 5.
  localparam int TEMP_MUL    = 1680;
  localparam int TEMP_OFFSET = 162791;
  localparam int TEMP_SHIFT  = 16;
  localparam int TEMP_ACC_W  = 24;

  // Reported limit sits this far below the measured temperature.
  localparam logic [TEMP_W-1:0] LIMIT_MARGIN = TEMP_W'(2);

  localparam logic [CNT_W-1:0]  PERIOD_RESET = CNT_W'(100);
  localparam logic [TEMP_W-1:0] TEMP_RESET   = TEMP_W'(11);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_GAIN_POS      = 3'd1,
    REG_GAIN_NEG      = 3'd2,
    REG_PERIOD        = 3'd3,
    REG_DUTY_HIGH     = 3'd4,
    REG_WDOG_TEMP     = 3'd5,
    REG_OVERHEAT      = 3'd6,
    REG_COOLDOWN      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] setpoint;
    logic [GAIN_W-1:0] gain_positive;
    logic [GAIN_W-1:0] gain_negative;
    logic [CNT_W-1:0]  control_period;
    logic [CNT_W-1:0]  duty_high_threshold;
    logic [TEMP_W-1:0] watchdog_enable_temp;
    logic [CNT_W-1:0]  overheat_ticks;
    logic [CNT_W-1:0]  cooldown_ticks;
  } stihr_cfg_t;

  // One tick after the temperature conversion.
  typedef struct packed {
    logic [TEMP_W-1:0] tip_temp;
    logic              run_enable;
    logic              pwm_is_low;
  } stihr_tick_t;

  // Fields of the result beat, lowest field last here (packed order).
  typedef struct packed {
    logic              cooling;
    logic [TEMP_W-1:0] temp_limit;
    logic              overheat_event;
    logic [TEMP_W-1:0] tip_temp;
    logic [DUTY_W-1:0] duty;
  } stihr_result_t;

  function automatic logic [TEMP_W-1:0] tip_from_adc(input logic [ADC_W-1:0] adc);
    logic [TEMP_ACC_W-1:0] acc;
    acc = TEMP_ACC_W'(adc) * TEMP_ACC_W'(TEMP_MUL) + TEMP_ACC_W'(TEMP_OFFSET);
    return acc[TEMP_SHIFT +: TEMP_W];
  endfunction

endpackage

// File: hdl/stihr_regulator.sv
// Regulator state and per-tick update: period divider, duty update,
// overheat watchdog and cooldown. Depends on stihr_pkg.
`timescale 1ns / 1ps

module stihr_regulator import stihr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,      // consume one tick this cycle
  input  stihr_tick_t   tick,
  input  stihr_cfg_t    cfg,
  output stihr_result_t result     // outcome of the tick being consumed
);

  localparam int ERR_W  = TEMP_W + 1;
  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int SUM_W  = ((DUTY_VAL_W > PROD_W) ? DUTY_VAL_W : PROD_W) + 2;

  logic [CNT_W-1:0]      period_counter, period_counter_next;
  logic [CNT_W-1:0]      cooldown_counter, cooldown_counter_next;
  logic [CNT_W-1:0]      overheat_counter, overheat_counter_next;
  logic [DUTY_VAL_W-1:0] duty_value, duty_value_next;
  logic [TEMP_W-1:0]     measured_temp, measured_temp_next;
  logic [TEMP_W-1:0]     limit_value, limit_value_next;

  logic signed [ERR_W-1:0]  err;
  logic [GAIN_W-1:0]        gain;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic [DUTY_VAL_W-1:0]    duty_upd;
  logic [CNT_W-1:0]         duty_ext;
  logic                     duty_hot;
  logic [CNT_W-1:0]         wd_count;
  logic [CNT_W-1:0]         cd_pre;
  logic                     event_fire;

  // Duty update arithmetic, from the fresh sample.
  always_comb begin
    err  = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, tick.tip_temp});
    gain = (err > 0) ? cfg.gain_positive : cfg.gain_negative;
    prod = PROD_W'(err) * $signed({1'b0, gain});
    sum  = $signed({{(SUM_W - DUTY_VAL_W){1'b0}}, duty_value})
         + $signed({{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod});
    if (sum < 0) begin
      duty_upd = '0;
    end else if (sum > $signed(SUM_W'(DUTY_MAX))) begin
      duty_upd = DUTY_VAL_W'(DUTY_MAX);
    end else begin
      duty_upd = sum[DUTY_VAL_W-1:0];
    end
  end

  always_comb begin
    period_counter_next   = period_counter;
    overheat_counter_next = overheat_counter;
    duty_value_next       = duty_value;
    measured_temp_next    = measured_temp;
    limit_value_next      = limit_value;
    cd_pre                = cooldown_counter;
    event_fire            = 1'b0;
    wd_count              = overheat_counter;
    duty_ext              = '0;
    duty_hot              = 1'b0;

    if (tick.run_enable) begin
      if (period_counter != '0) begin
        period_counter_next = period_counter - 1'b1;
      end else if (cooldown_counter == '0) begin
        if (tick.pwm_is_low) begin
          measured_temp_next  = tick.tip_temp;
          duty_value_next     = duty_upd;
          period_counter_next = cfg.control_period;
        end
        // watchdog sees the duty after any update
        duty_ext = CNT_W'(duty_value_next);
        duty_hot = duty_ext >= cfg.duty_high_threshold;
        if (wd_count < cfg.overheat_ticks && cfg.setpoint >= cfg.watchdog_enable_temp
            && duty_hot) begin
          wd_count = wd_count + 1'b1;
        end
        if (wd_count != '0 && wd_count < cfg.overheat_ticks && !duty_hot) begin
          wd_count = wd_count - 1'b1;
        end
        if (wd_count >= cfg.overheat_ticks) begin
          event_fire       = 1'b1;
          limit_value_next = (measured_temp_next >= LIMIT_MARGIN)
                           ? measured_temp_next - LIMIT_MARGIN : '0;
          duty_value_next  = '0;
          wd_count         = '0;
          cd_pre           = cfg.cooldown_ticks;
        end
        overheat_counter_next = wd_count;
      end else begin
        duty_value_next = '0;
      end
    end else begin
      duty_value_next = '0;
    end

    // cooldown runs every tick, even the one that loaded it
    cooldown_counter_next = (cd_pre != '0) ? cd_pre - 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_counter   <= PERIOD_RESET;
      cooldown_counter <= '0;
      overheat_counter <= '0;
      duty_value       <= '0;
      measured_temp    <= TEMP_RESET;
      limit_value      <= '0;
    end else if (step) begin
      period_counter   <= period_counter_next;
      cooldown_counter <= cooldown_counter_next;
      overheat_counter <= overheat_counter_next;
      duty_value       <= duty_value_next;
      measured_temp    <= measured_temp_next;
      limit_value      <= limit_value_next;
    end
  end

  always_comb begin
    result.duty           = DUTY_W'(duty_value_next);
    result.tip_temp       = measured_temp_next;
    result.overheat_event = event_fire;
    result.temp_limit     = limit_value_next;
    result.cooling        = cooldown_counter_next != '0;
  end

endmodule

// File: hdl/solder_tip_heater_regulator.sv
// Top level of the solder tip heater regulator: stream ports, register
// file, tick input register and result register. Depends on stihr_pkg
// and stihr_regulator.
`timescale 1ns / 1ps

// Channel   Dir  Beat                        Width
// s_axis    in   one timer tick              16 (adc_sample, run_enable, pwm_is_low)
// m_axis    out  one result per tick         32 (duty, tip_temp, event, limit, cooling)
// cfg       in   register write              3 index + 16 data
//
// From input beat to result beat a tick passes the tick register, then the
// result register: the temperature conversion sits before the tick register,
// the control and watchdog update between the two. One tick is accepted
// per cycle; the state loop closes in the second stage. rst (synchronous)
// restores register and state reset values. A stalled m_axis holds the
// result and back-pressures s_axis only once both stages are full.

module solder_tip_heater_regulator import stihr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // adc_sample[11:0], run_enable, pwm_is_low
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // duty[9:0], tip_temp, overheat_event,
                                               // temp_limit, cooling
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  stihr_cfg_t    cfg;
  stihr_tick_t   tick, tick_in;
  logic          tick_valid;
  stihr_result_t result, result_comb;
  logic          result_valid;
  logic          advance;

  // Register file; writes are taken every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint             <= TEMP_W'(10);
      cfg.gain_positive        <= GAIN_W'(1);
      cfg.gain_negative        <= GAIN_W'(1);
      cfg.control_period       <= PERIOD_RESET;
      cfg.duty_high_threshold  <= CNT_W'(800);
      cfg.watchdog_enable_temp <= TEMP_W'(60);
      cfg.overheat_ticks       <= CNT_W'(1000);
      cfg.cooldown_ticks       <= CNT_W'(1000);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SETPOINT:  cfg.setpoint             <= cfg_data[TEMP_W-1:0];
        REG_GAIN_POS:  cfg.gain_positive        <= cfg_data[GAIN_W-1:0];
        REG_GAIN_NEG:  cfg.gain_negative        <= cfg_data[GAIN_W-1:0];
        REG_PERIOD:    cfg.control_period       <= cfg_data[CNT_W-1:0];
        REG_DUTY_HIGH: cfg.duty_high_threshold  <= cfg_data[CNT_W-1:0];
        REG_WDOG_TEMP: cfg.watchdog_enable_temp <= cfg_data[TEMP_W-1:0];
        REG_OVERHEAT:  cfg.overheat_ticks       <= cfg_data[CNT_W-1:0];
        REG_COOLDOWN:  cfg.cooldown_ticks       <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: convert the sample on the way into the tick register.
  always_comb begin
    tick_in.tip_temp   = tip_from_adc(s_axis_tdata[ADC_W-1:0]);
    tick_in.run_enable = s_axis_tdata[ADC_W];
    tick_in.pwm_is_low = s_axis_tdata[ADC_W+1];
  end

  // Stage 2 consumes the tick when the result register is free or draining.
  assign advance       = tick_valid && (!result_valid || m_axis_tready);
  assign s_axis_tready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (s_axis_tready) begin
      tick_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick <= tick_in;
    end
  end

  stihr_regulator u_regulator (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .tick   (tick),
    .cfg    (cfg),
    .result (result_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (m_axis_tready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_comb;
    end
  end

  assign m_axis_tvalid = result_valid;
  assign m_axis_tdata  = {4'b0, result};

`ifndef NO_ASSERTIONS
  // The cutoff always leaves the heater off.
  a_event_duty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overheat_event |-> result.duty == '0)
    else $error("overheat event with nonzero duty");

  // No duty while the cooldown is running.
  a_cooling_duty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.cooling |-> result.duty == '0)
    else $error("duty nonzero during cooldown");

  // A tick taken while stopped yields zero duty.
  a_stopped_duty_zero: assert property (@(posedge clk) disable iff (rst)
    advance && !tick.run_enable |=> result.duty == '0)
    else $error("duty nonzero while stopped");
`endif

endmodule

// File: test/tb_solder_tip_heater_regulator.sv
// Testbench for solder_tip_heater_regulator: clocked tick driver and result
// receiver with random gaps, a tick-level regulator predictor and in-order checks.
// Depends on stihr_pkg and the regulator RTL.
`timescale 1ns / 1ps

module tb_solder_tip_heater_regulator;
  import stihr_pkg::*;

  // Q16 temperature conversion, 5 degree units
  localparam int TIP_MUL_Q16 = 1680;
  localparam int TIP_OFS_Q16 = 162791;
  localparam int TIP_MAX     = 107;
  localparam int LIMIT_DROP  = 2;

  localparam int RES_W       = $bits(stihr_result_t);
  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat on any channel
  localparam int LONG_HOLD   = 60;    // receiver hold-off, fills both stages
  localparam int MAX_GAP     = 14;
  localparam int SHOW_MAX    = 10;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_TICKS = 75;
  localparam int LAST_TICKS  = 40;

  typedef struct {
    logic [ADC_W-1:0] adc;
    logic             run;
    logic             pwm_low;
    int               gap;      // idle cycles before the beat is offered
  } tick_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // adc_sample[11:0], run_enable, pwm_is_low
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;        // duty, tip_temp, overheat_event,
                                              // temp_limit, cooling
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  solder_tip_heater_regulator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Regulator predictor: register copy plus tick state
  // ---------------------------------------------------------------------
  stihr_cfg_t regs_now;
  int period_left, cool_left, heat_count, duty_now, temp_now, limit_now;

  function automatic stihr_result_t regulate_tick(logic [ADC_W-1:0] adc, logic run,
                                                  logic pwm_low);
    stihr_result_t r;
    logic          fired;
    int            err, lim, hi;
    fired = 1'b0;
    lim   = int'(regs_now.overheat_ticks);
    hi    = int'(regs_now.duty_high_threshold);
    if (!run) begin
      duty_now = 0;
    end else if (period_left > 0) begin
      period_left--;
    end else if (cool_left != 0) begin
      duty_now = 0;
    end else begin
      if (pwm_low) begin
        temp_now = (int'(adc) * TIP_MUL_Q16 + TIP_OFS_Q16) >>> 16;
        err = int'(regs_now.setpoint) - temp_now;
        if (err > 0) err = err * int'(regs_now.gain_positive);
        else err = err * int'(regs_now.gain_negative);
        duty_now = duty_now + err;
        if (duty_now < 0) duty_now = 0;
        if (duty_now > DUTY_MAX) duty_now = DUTY_MAX;
        period_left = int'(regs_now.control_period);
      end
      // overheat watchdog: rises while hot and high, falls while low
      if (heat_count < lim && regs_now.setpoint >= regs_now.watchdog_enable_temp &&
          duty_now >= hi)
        heat_count++;
      if (heat_count > 0 && heat_count < lim && duty_now < hi)
        heat_count--;
      if (heat_count >= lim) begin
        limit_now  = (temp_now >= LIMIT_DROP) ? temp_now - LIMIT_DROP : 0;
        duty_now   = 0;
        heat_count = 0;
        cool_left  = int'(regs_now.cooldown_ticks);
        fired      = 1'b1;
      end
    end
    if (cool_left > 0) cool_left--;
    r.duty           = DUTY_W'(duty_now);
    r.tip_temp       = TEMP_W'(temp_now);
    r.overheat_event = fired;
    r.temp_limit     = TEMP_W'(limit_now);
    r.cooling        = (cool_left != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Tick driver: pops pending ticks, waits each one's gap, offers the beat
  // ---------------------------------------------------------------------
  tick_item_t    pending_ticks[$];
  stihr_result_t due_results[$];
  tick_item_t    tx_item = '{adc: '0, run: 1'b0, pwm_low: 1'b0, gap: 0};
  logic          tx_armed = 1'b0;
  logic          tx_offer = 1'b0;
  logic          tx_quiet = 1'b0;
  int            tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (tx_offer && s_axis_tready) begin
        due_results.push_back(regulate_tick(tx_item.adc, tx_item.run, tx_item.pwm_low));
        tx_offer = 1'b0;
      end
      if (!tx_offer) begin
        if (!tx_armed && pending_ticks.size() != 0) begin
          tx_item  = pending_ticks.pop_front();
          tx_gap   = tx_item.gap;
          tx_armed = 1'b1;
        end
        if (tx_armed) begin
          if (tx_gap == 0) begin
            tx_offer = 1'b1;
            tx_armed = 1'b0;
          end else begin
            tx_gap--;
          end
        end
      end
      s_axis_tvalid <= tx_offer;
      s_axis_tdata  <= {2'b00, tx_item.pwm_low, tx_item.run, tx_item.adc};
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver: random stalls, long hold-off on request, checking
  // ---------------------------------------------------------------------
  int   rx_wait = 0;
  logic rx_quiet = 1'b0;
  logic hold_req = 1'b0;
  int   mismatches = 0;

  always @(posedge clk) begin : rx_side
    stihr_result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = stihr_result_t'(m_axis_tdata[RES_W-1:0]);
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("result beat with no tick waiting: %h", m_axis_tdata);
        end else begin
          want = due_results.pop_front();
          if (got.duty !== want.duty || got.tip_temp !== want.tip_temp ||
              got.overheat_event !== want.overheat_event ||
              got.temp_limit !== want.temp_limit || got.cooling !== want.cooling ||
              m_axis_tdata[31:RES_W] !== '0) begin
            mismatches++;
            if (mismatches <= SHOW_MAX) begin
              $display("mismatch: want duty %0d temp %0d evt %0b limit %0d cool %0b",
                       want.duty, want.tip_temp, want.overheat_event, want.temp_limit,
                       want.cooling);
              $display("          got  duty %0d temp %0d evt %0b limit %0d cool %0b pad %h",
                       got.duty, got.tip_temp, got.overheat_event, got.temp_limit,
                       got.cooling, m_axis_tdata[31:RES_W]);
            end
          end
        end
        rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end else if (!m_axis_tready && rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_req) begin
        rx_wait  = LONG_HOLD;
        hold_req = 1'b0;
      end
      m_axis_tready <= (rx_wait == 0);
    end
  end

  // Hang detector: no beat on any channel for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SETPOINT:  regs_now.setpoint             = value[7:0];
      REG_GAIN_POS:  regs_now.gain_positive        = value[7:0];
      REG_GAIN_NEG:  regs_now.gain_negative        = value[7:0];
      REG_PERIOD:    regs_now.control_period       = value;
      REG_DUTY_HIGH: regs_now.duty_high_threshold  = value;
      REG_WDOG_TEMP: regs_now.watchdog_enable_temp = value[7:0];
      REG_OVERHEAT:  regs_now.overheat_ticks       = value;
      REG_COOLDOWN:  regs_now.cooldown_ticks       = value;
      default: ;
    endcase
  endtask

  // 8-bit registers get junk in the upper byte, which must be dropped
  task automatic write_all(input int sp, gp, gn, per, dh, wt, oh, cd);
    write_reg(REG_SETPOINT,  {8'($urandom), 8'(sp)});
    write_reg(REG_GAIN_POS,  {8'($urandom), 8'(gp)});
    write_reg(REG_GAIN_NEG,  {8'($urandom), 8'(gn)});
    write_reg(REG_PERIOD,    16'(per));
    write_reg(REG_DUTY_HIGH, 16'(dh));
    write_reg(REG_WDOG_TEMP, {8'($urandom), 8'(wt)});
    write_reg(REG_OVERHEAT,  16'(oh));
    write_reg(REG_COOLDOWN,  16'(cd));
  endtask

  task automatic queue_tick(input logic [ADC_W-1:0] adc, input logic run,
                            input logic pwm_low);
    tick_item_t t;
    t.adc     = adc;
    t.run     = run;
    t.pwm_low = pwm_low;
    t.gap     = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    pending_ticks.push_back(t);
  endtask

  // wait until every tick is sent and every result is back, then settle
  task automatic drain();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || tx_armed || tx_offer || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // mostly typical values, sometimes zero or the top value
  function automatic int pick(int lo, int hi, int top);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // sample that lands near a given temperature, with some noise
  function automatic logic [ADC_W-1:0] adc_near(int t);
    int a;
    if (t < 2) t = 2;
    if (t > TIP_MAX) t = TIP_MAX;
    a = ((t << 16) - TIP_OFS_Q16) / TIP_MUL_Q16 + int'($urandom_range(0, 60)) - 30;
    if (a < 0) a = 0;
    if (a > 4095) a = 4095;
    return ADC_W'(a);
  endfunction

  task automatic random_ticks(input int count);
    logic [ADC_W-1:0] adc;
    int               n;
    for (n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0:       adc = '0;
        1:       adc = '1;
        2, 3, 4: adc = ADC_W'($urandom);
        default: adc = adc_near(int'(regs_now.setpoint));
      endcase
      // mostly enabled runs so the control loop and watchdog get exercised
      queue_tick(adc, $urandom_range(0, 19) != 0, $urandom_range(0, 9) < 6);
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int k, n;
    regs_now = '{setpoint: 8'd10, gain_positive: 8'd1, gain_negative: 8'd1,
                 control_period: 16'd100, duty_high_threshold: 16'd800,
                 watchdog_enable_temp: 8'd60, overheat_ticks: 16'd1000,
                 cooldown_ticks: 16'd1000};
    period_left = 100;
    cool_left   = 0;
    heat_count  = 0;
    duty_now    = 0;
    temp_now    = 11;
    limit_now   = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset values: disabled ticks hold the counters, then the 100-tick
    // countdown; finish with the PWM high so no reload leaves a long period.
    queue_tick('0, 1'b0, 1'b1);
    queue_tick('1, 1'b0, 1'b0);
    queue_tick(12'hAAA, 1'b0, 1'b1);
    queue_tick(12'h555, 1'b0, 1'b0);
    for (n = 0; n < 100; n++) queue_tick(ADC_W'($urandom), 1'b1, 1'(n));
    for (n = 0; n < 10; n++) queue_tick(ADC_W'($urandom), 1'b1, 1'b0);
    drain();

    // Full gains, hottest setpoint: duty clamps at the top, PWM high skips the
    // update, disabled forces zero.
    write_all(255, 255, 255, 0, 65535, 255, 65535, 0);
    queue_tick('0, 1'b1, 1'b1);
    queue_tick('1, 1'b1, 1'b1);
    queue_tick('0, 1'b1, 1'b0);
    queue_tick('0, 1'b0, 1'b1);
    queue_tick('1, 1'b1, 1'b1);
    queue_tick(12'h800, 1'b1, 1'b1);
    drain();

    // Zero overheat limit: cutoff on every watchdog run; negative error clamps
    // duty at zero; short cooldown holds the heater off.
    write_all(0, 0, 255, 0, 0, 0, 0, 2);
    queue_tick('1, 1'b1, 1'b1);
    queue_tick('0, 1'b1, 1'b1);
    queue_tick('0, 1'b1, 1'b1);
    queue_tick('0, 1'b1, 1'b0);
    queue_tick(12'h123, 1'b1, 1'b1);
    drain();

    // Zero error takes the negative gain; watchdog climbs to its limit and
    // the coldest reading brings the reported limit down to zero.
    write_all(100, 1, 1, 1, 0, 0, 3, 5);
    queue_tick(12'd3805, 1'b1, 1'b1);
    queue_tick(12'd3805, 1'b1, 1'b1);
    for (n = 0; n < 6; n++) queue_tick('0, 1'b1, n != 1);
    drain();

    // Random settings and ticks; one phase with a gapless sender under a
    // long receiver hold-off, some without receiver stalls.
    for (k = 0; k < RAND_PHASES; k++) begin
      rx_quiet = (k == 4 || k == 6);
      tx_quiet = (k == 2 || k == 6);
      write_all(pick(0, 110, 255), pick(0, 12, 255), pick(0, 12, 255), pick(0, 3, 12),
                pick(0, 1023, 65535), pick(0, 110, 255), pick(1, 12, 65535),
                pick(0, 20, 40));
      random_ticks(PHASE_TICKS);
      if (k == 2) begin
        @(negedge clk);
        hold_req = 1'b1;
      end
      drain();
      rx_quiet = 1'b0;
      tx_quiet = 1'b0;
    end

    // Longest period and cooldown last, since neither runs out within the test
    write_all(pick(0, 110, 255), pick(0, 12, 255), pick(0, 12, 255), 65535,
              pick(0, 1023, 65535), pick(0, 110, 255), 0, 65535);
    random_ticks(LAST_TICKS);
    drain();

    repeat (8) @(negedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
